>>> rtl/core/byte_ring_fifo_with_timed_read_defines.svh
// Assertion macros shared by the ring FIFO modules.
`ifndef BYTE_RING_FIFO_WITH_TIMED_READ_DEFINES_SVH
`define BYTE_RING_FIFO_WITH_TIMED_READ_DEFINES_SVH

// Checked on the block clock, off while reset is high.
`define BRF_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Condition in a cycle implies a fact in the next.
`define BRF_ASSERT_NEXT(lbl, cond, nxt, msg) \
   `BRF_ASSERT(lbl, (cond) |=> (nxt), msg)

`endif

>>> rtl/core/brf_pkg.sv
// Types, constants and command/status structs for the byte ring FIFO.
package brf_pkg;

   localparam int BUFFER_DEPTH = 2048;
   localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
   localparam int MAX_READ     = 64;
   localparam int BYTE_W       = 8;
   localparam int LEN_W        = 7;
   localparam int FILL_W       = 11;
   localparam int TIMEOUT_W    = 16;
   localparam int STEP_W       = 10;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 16;
   localparam int CMP_W        = (ADDR_W > LEN_W) ? ADDR_W : LEN_W;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(1000);
   localparam logic [STEP_W-1:0]    STEP_RESET    = STEP_W'(30);

   typedef enum logic [1:0] {
      KIND_PUSH = 2'd0,
      KIND_READ = 2'd1,
      KIND_TICK = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_SHORT   = 2'd1,
      ST_TIMEOUT = 2'd2,
      ST_BUSY    = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TIMEOUT   = 1'b0,
      CSR_POLL_STEP = 1'b1
   } csr_reg_type;

   typedef enum logic [1:0] {
      S_IDLE  = 2'd0,
      S_FETCH = 2'd1,
      S_EMIT  = 2'd2
   } state_type;

   typedef struct packed {
      logic       push;
      logic       set_pending;
      logic       clear_pending;
      logic       tick_budget;
      logic       start_read;
      logic       from_pending;
      logic       fetch;
      logic       emit;
      logic       single;
      status_type single_status;
      logic       flush;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
      logic pending;
      logic req_fits;
      logic req_len_zero;
      logic pend_fits;
      logic pend_len_zero;
      logic budget_spent;
      logic timeout_zero;
      logic cnt_last;
   } dp_status_type;

endpackage

>>> rtl/core/brf_datapath.sv
// Datapath: byte store, ring indices, wait budget, config and result register.
`include "byte_ring_fifo_with_timed_read_defines.svh"

module brf_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  brf_pkg::dp_cmd_type                cmd,
   output brf_pkg::dp_status_type             status,
   input  logic                               csr_valid,
   input  logic [brf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [brf_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [brf_pkg::BYTE_W-1:0]         req_push_byte,
   input  logic [brf_pkg::LEN_W-1:0]          req_read_length,
   input  logic                               rsp_stall,
   output logic                               rsp_valid,
   output logic [1:0]                         rsp_status,
   output logic [brf_pkg::BYTE_W-1:0]         rsp_read_byte,
   output logic                               rsp_last,
   output logic [brf_pkg::FILL_W-1:0]         rsp_fill_count
);

   function automatic logic [brf_pkg::ADDR_W-1:0] idx_next(
      input logic [brf_pkg::ADDR_W-1:0] i
   );
      if (i == brf_pkg::ADDR_W'(brf_pkg::BUFFER_DEPTH - 1)) begin
         return '0;
      end
      return i + 1'b1;
   endfunction

   logic [brf_pkg::BYTE_W-1:0]    mem [brf_pkg::BUFFER_DEPTH];
   logic [brf_pkg::BYTE_W-1:0]    rd_data_ff;

   logic [brf_pkg::TIMEOUT_W-1:0] timeout_ff;
   logic [brf_pkg::STEP_W-1:0]    step_ff;
   logic [brf_pkg::ADDR_W-1:0]    wr_idx_ff, wr_idx_in;
   logic [brf_pkg::ADDR_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                          pending_ff, pending_in;
   logic [brf_pkg::LEN_W-1:0]     pend_len_ff, pend_len_in;
   logic [brf_pkg::TIMEOUT_W-1:0] budget_ff, budget_in;
   logic [brf_pkg::LEN_W-1:0]     cnt_ff, cnt_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   brf_pkg::status_type           rsp_status_ff;
   logic [brf_pkg::BYTE_W-1:0]    rsp_byte_ff;
   logic                          rsp_last_ff;
   logic [brf_pkg::FILL_W-1:0]    rsp_fill_ff;

   logic [brf_pkg::ADDR_W-1:0]    fill;
   logic [brf_pkg::LEN_W-1:0]     req_len_sat;
   logic [brf_pkg::STEP_W-1:0]    step_eff;
   logic                          budget_over;
   logic [brf_pkg::TIMEOUT_W-1:0] budget_dec;

   // occupancy modulo the ring depth
   always_comb begin
      if (wr_idx_ff >= rd_idx_ff) begin
         fill = wr_idx_ff - rd_idx_ff;
      end else begin
         fill = brf_pkg::ADDR_W'(brf_pkg::BUFFER_DEPTH - int'(rd_idx_ff) + int'(wr_idx_ff));
      end
   end

   assign req_len_sat = (req_read_length > brf_pkg::LEN_W'(brf_pkg::MAX_READ)) ?
                        brf_pkg::LEN_W'(brf_pkg::MAX_READ) : req_read_length;

   assign step_eff    = (step_ff == '0) ? brf_pkg::STEP_W'(1) : step_ff;
   assign budget_over = budget_ff > brf_pkg::TIMEOUT_W'(step_eff);
   assign budget_dec  = budget_over ? budget_ff - brf_pkg::TIMEOUT_W'(step_eff) : '0;

   always_comb begin
      status.out_free      = !rsp_valid_ff || !rsp_stall;
      status.pending       = pending_ff;
      status.req_fits      = brf_pkg::CMP_W'(fill) >= brf_pkg::CMP_W'(req_len_sat);
      status.req_len_zero  = req_len_sat == '0;
      status.pend_fits     = brf_pkg::CMP_W'(fill) >= brf_pkg::CMP_W'(pend_len_ff);
      status.pend_len_zero = pend_len_ff == '0;
      status.budget_spent  = !budget_over;
      status.timeout_zero  = timeout_ff == '0;
      status.cnt_last      = cnt_ff == brf_pkg::LEN_W'(1);
   end

   always_comb begin
      wr_idx_in   = cmd.push ? idx_next(wr_idx_ff) : wr_idx_ff;

      rd_idx_in   = rd_idx_ff;
      if (cmd.flush) begin
         rd_idx_in = wr_idx_ff;
      end else if (cmd.emit) begin
         rd_idx_in = idx_next(rd_idx_ff);
      end

      pending_in  = pending_ff;
      pend_len_in = pend_len_ff;
      budget_in   = budget_ff;
      if (cmd.clear_pending) begin
         pending_in  = 1'b0;
         pend_len_in = '0;
         budget_in   = '0;
      end else if (cmd.set_pending) begin
         pending_in  = 1'b1;
         pend_len_in = req_len_sat;
         budget_in   = timeout_ff;
      end else if (cmd.tick_budget) begin
         budget_in   = budget_dec;
      end

      cnt_in = cnt_ff;
      if (cmd.start_read) begin
         cnt_in = cmd.from_pending ? pend_len_ff : req_len_sat;
      end else if (cmd.emit) begin
         cnt_in = cnt_ff - 1'b1;
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.single || cmd.emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= brf_pkg::TIMEOUT_RESET;
         step_ff      <= brf_pkg::STEP_RESET;
         wr_idx_ff    <= '0;
         rd_idx_ff    <= '0;
         pending_ff   <= 1'b0;
         pend_len_ff  <= '0;
         budget_ff    <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (brf_pkg::csr_reg_type'(csr_index))
               brf_pkg::CSR_TIMEOUT:   timeout_ff <= brf_pkg::TIMEOUT_W'(csr_wdata);
               brf_pkg::CSR_POLL_STEP: step_ff    <= brf_pkg::STEP_W'(csr_wdata);
               default: ;
            endcase
         end
         wr_idx_ff    <= wr_idx_in;
         rd_idx_ff    <= rd_idx_in;
         pending_ff   <= pending_in;
         pend_len_ff  <= pend_len_in;
         budget_ff    <= budget_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // byte store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[wr_idx_ff] <= req_push_byte;
      end
      if (cmd.fetch) begin
         rd_data_ff <= mem[rd_idx_ff];
      end
   end

   // result payload; fill is taken before the flush or the byte removal
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_status_ff <= brf_pkg::ST_OK;
         rsp_byte_ff   <= rd_data_ff;
         rsp_last_ff   <= status.cnt_last;
         rsp_fill_ff   <= brf_pkg::FILL_W'(fill);
      end else if (cmd.single) begin
         rsp_status_ff <= cmd.single_status;
         rsp_byte_ff   <= '0;
         rsp_last_ff   <= 1'b1;
         rsp_fill_ff   <= brf_pkg::FILL_W'(fill);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_byte  = rsp_byte_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_fill_count = rsp_fill_ff;

   `BRF_ASSERT_NEXT(a_flush_empties, cmd.flush, fill == '0, "ring not empty after flush")
   `BRF_ASSERT_NEXT(a_clear_pending, cmd.clear_pending, !pending_ff, "pending read not cleared")
   `BRF_ASSERT_NEXT(a_arm_budget, cmd.set_pending, budget_ff != '0, "waiting read armed with no budget")

endmodule

>>> rtl/core/brf_ctrl.sv
// Controller: decodes accepted beats and sequences the byte read-out.
`include "byte_ring_fifo_with_timed_read_defines.svh"

module brf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_kind,
   input  logic                   req_wait_mode,
   output logic                   req_stall,
   input  brf_pkg::dp_status_type status,
   output brf_pkg::dp_cmd_type    cmd
);

   brf_pkg::state_type state_ff, state_in;
   logic               accept;

   assign req_stall = !(state_ff == brf_pkg::S_IDLE && status.out_free);
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= brf_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.single_status = brf_pkg::ST_OK;
      unique case (state_ff)
         brf_pkg::S_IDLE: begin
            if (accept) begin
               unique case (brf_pkg::kind_type'(req_kind))
                  brf_pkg::KIND_PUSH: begin
                     cmd.push = 1'b1;
                  end
                  brf_pkg::KIND_READ: begin
                     priority if (status.pending) begin
                        cmd.single        = 1'b1;
                        cmd.single_status = brf_pkg::ST_BUSY;
                     end else if (status.req_fits) begin
                        if (status.req_len_zero) begin
                           cmd.single = 1'b1;
                        end else begin
                           cmd.start_read = 1'b1;
                           state_in       = brf_pkg::S_FETCH;
                        end
                     end else if (!req_wait_mode) begin
                        cmd.single        = 1'b1;
                        cmd.single_status = brf_pkg::ST_SHORT;
                     end else if (status.timeout_zero) begin
                        cmd.single        = 1'b1;
                        cmd.single_status = brf_pkg::ST_TIMEOUT;
                        cmd.flush         = 1'b1;
                     end else begin
                        cmd.set_pending = 1'b1;
                     end
                  end
                  brf_pkg::KIND_TICK: begin
                     if (status.pending) begin
                        cmd.tick_budget = 1'b1;
                        priority if (status.pend_fits) begin
                           cmd.clear_pending = 1'b1;
                           if (status.pend_len_zero) begin
                              cmd.single = 1'b1;
                           end else begin
                              cmd.start_read   = 1'b1;
                              cmd.from_pending = 1'b1;
                              state_in         = brf_pkg::S_FETCH;
                           end
                        end else if (status.budget_spent) begin
                           cmd.clear_pending = 1'b1;
                           cmd.single        = 1'b1;
                           cmd.single_status = brf_pkg::ST_TIMEOUT;
                           cmd.flush         = 1'b1;
                        end else begin
                           cmd.tick_budget = 1'b1;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         brf_pkg::S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = brf_pkg::S_EMIT;
         end
         brf_pkg::S_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = status.cnt_last ? brf_pkg::S_IDLE : brf_pkg::S_FETCH;
            end
         end
         default: begin
            state_in = brf_pkg::S_IDLE;
         end
      endcase
   end

   `BRF_ASSERT_NEXT(a_fetch_to_emit, state_ff == brf_pkg::S_FETCH, state_ff == brf_pkg::S_EMIT, "fetch not followed by emit")
   `BRF_ASSERT_NEXT(a_emit_holds, state_ff == brf_pkg::S_EMIT && !status.out_free, state_ff == brf_pkg::S_EMIT, "left emit while output busy")
   `BRF_ASSERT_NEXT(a_run_ends, state_ff == brf_pkg::S_EMIT && status.out_free && status.cnt_last, state_ff == brf_pkg::S_IDLE, "run did not end after last beat")

endmodule

>>> rtl/core/byte_ring_fifo_with_timed_read.sv
// Push/read/tick beats: a single-result beat shows its result the next cycle.
// A successful read of N bytes (N > 0) runs, per byte, a fetch on the store's registered
// read port and then a load of the output register, which waits while the output stalls.
// New beats are held off while a read run is active or a result in the output register is stalled.
// Reset clears indices, pending read and budget, sets timeout 1000 and poll step 30;
// the byte store is not cleared and needs no clearing pass.
module byte_ring_fifo_with_timed_read (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_kind,
   input  logic [brf_pkg::BYTE_W-1:0]     req_push_byte,
   input  logic [brf_pkg::LEN_W-1:0]      req_read_length,
   input  logic                           req_wait_mode,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_status,
   output logic [brf_pkg::BYTE_W-1:0]     rsp_read_byte,
   output logic                           rsp_last,
   output logic [brf_pkg::FILL_W-1:0]     rsp_fill_count,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [brf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [brf_pkg::CSR_DATA_W-1:0] csr_wdata
);

   brf_pkg::dp_cmd_type    cmd;
   brf_pkg::dp_status_type status;

   // config writes are always taken
   assign csr_ready = 1'b1;

   brf_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_kind      (req_kind),
      .req_wait_mode (req_wait_mode),
      .req_stall     (req_stall),
      .status        (status),
      .cmd           (cmd)
   );

   brf_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_valid       (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_push_byte   (req_push_byte),
      .req_read_length (req_read_length),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_read_byte   (rsp_read_byte),
      .rsp_last        (rsp_last),
      .rsp_fill_count  (rsp_fill_count)
   );

endmodule

>>> tb/tb_byte_ring_fifo_with_timed_read.sv
// Self-checking testbench for the byte ring FIFO with timed, all-or-nothing reads.
module tb_byte_ring_fifo_with_timed_read;
   timeunit 1ns;
   timeprecision 1ps;

   import brf_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 400_000;

   typedef struct {
      logic [1:0]        kind;
      logic [BYTE_W-1:0] push_byte;
      logic [LEN_W-1:0]  read_length;
      logic              wait_mode;
   } fifo_beat_type;

   typedef struct {
      status_type        st;
      logic [BYTE_W-1:0] data;
      logic              last;
      logic [FILL_W-1:0] fill;
   } fifo_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_kind = KIND_PUSH;
   logic [BYTE_W-1:0]     req_push_byte = '0;
   logic [LEN_W-1:0]      req_read_length = '0;
   logic                  req_wait_mode = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [1:0]            rsp_status;
   logic [BYTE_W-1:0]     rsp_read_byte;
   logic                  rsp_last;
   logic [FILL_W-1:0]     rsp_fill_count;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_TIMEOUT;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   byte_ring_fifo_with_timed_read u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_push_byte   (req_push_byte),
      .req_read_length (req_read_length),
      .req_wait_mode   (req_wait_mode),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_read_byte   (rsp_read_byte),
      .rsp_last        (rsp_last),
      .rsp_fill_count  (rsp_fill_count),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial forever #1 clock = ~clock;

   fifo_beat_type   beat_q[$];
   fifo_result_type result_q[$];
   fifo_beat_type   next_beat;
   fifo_result_type want;
   int              send_gap_pct = 0;
   int              rsp_hold_pct = 0;
   bit              beat_taken = 1'b0;
   int              err_cnt = 0;
   int              cycle_cnt = 0;

   // Shadow copy of the FIFO state and its registers
   logic [BYTE_W-1:0]    ring_mem [BUFFER_DEPTH];
   logic [ADDR_W-1:0]    wr_ptr = '0;
   logic [ADDR_W-1:0]    rd_ptr = '0;
   bit                   rd_waiting = 1'b0;
   logic [LEN_W-1:0]     waiting_len = '0;
   logic [16:0]          budget_left = '0;
   logic [TIMEOUT_W-1:0] timeout_cfg = TIMEOUT_RESET;
   logic [STEP_W-1:0]    step_cfg = STEP_RESET;

   function automatic logic [FILL_W-1:0] stored_bytes();
      return FILL_W'(wr_ptr - rd_ptr);
   endfunction

   function automatic void push_single(input status_type st);
      result_q.push_back('{st, 8'h00, 1'b1, stored_bytes()});
   endfunction

   // All-or-nothing take of n bytes; a zero length gives one empty beat.
   function automatic bit take_bytes(input logic [LEN_W-1:0] n);
      logic [FILL_W-1:0] fill;
      int i;
      fill = stored_bytes();
      if (fill < n) return 1'b0;
      if (n == 0) begin
         result_q.push_back('{ST_OK, 8'h00, 1'b1, fill});
         return 1'b1;
      end
      for (i = 0; i < n; i++) begin
         result_q.push_back('{ST_OK, ring_mem[rd_ptr], (i + 1 == n), fill - FILL_W'(i)});
         rd_ptr = rd_ptr + 1'b1;
      end
      return 1'b1;
   endfunction

   task automatic fifo_beat_results(input fifo_beat_type b);
      logic [LEN_W-1:0]  len;
      logic [STEP_W-1:0] step;
      len = (b.read_length > MAX_READ) ? LEN_W'(MAX_READ) : b.read_length;
      case (b.kind)
         KIND_PUSH: begin
            ring_mem[wr_ptr] = b.push_byte;
            wr_ptr = wr_ptr + 1'b1;
         end
         KIND_READ: begin
            if (rd_waiting) begin
               push_single(ST_BUSY);
            end else if (!take_bytes(len)) begin
               if (!b.wait_mode) begin
                  push_single(ST_SHORT);
               end else if (timeout_cfg == 0) begin
                  push_single(ST_TIMEOUT);
                  rd_ptr = wr_ptr;
               end else begin
                  rd_waiting = 1'b1;
                  waiting_len = len;
                  budget_left = 17'(timeout_cfg);
               end
            end
         end
         KIND_TICK: begin
            if (rd_waiting) begin
               step = (step_cfg == 0) ? STEP_W'(1) : step_cfg;
               budget_left = (budget_left > step) ? budget_left - step : '0;
               // retry comes first, even on the tick that uses up the budget
               if (take_bytes(waiting_len)) begin
                  rd_waiting = 1'b0;
                  waiting_len = '0;
                  budget_left = '0;
               end else if (budget_left == 0) begin
                  push_single(ST_TIMEOUT);
                  rd_ptr = wr_ptr;
                  rd_waiting = 1'b0;
                  waiting_len = '0;
               end
            end
         end
         default: ;
      endcase
   endtask

   // Driver: new beat or bubble at the falling edge, payload held while stalled
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || beat_taken) begin
         beat_taken = 1'b0;
         if (beat_q.size() > 0 && $urandom_range(0, 99) >= send_gap_pct) begin
            next_beat = beat_q.pop_front();
            req_valid       <= 1'b1;
            req_kind        <= next_beat.kind;
            req_push_byte   <= next_beat.push_byte;
            req_read_length <= next_beat.read_length;
            req_wait_mode   <= next_beat.wait_mode;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < rsp_hold_pct);
   end

   // Monitor: predict on accepted input beats, check accepted result beats
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         fifo_beat_results('{req_kind, req_push_byte, req_read_length, req_wait_mode});
         beat_taken = 1'b1;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (result_q.size() == 0) begin
            $display("%0t ns: unexpected result beat status %0d byte %0d last %0d fill %0d",
                     $time, rsp_status, rsp_read_byte, rsp_last, rsp_fill_count);
            err_cnt++;
         end else begin
            want = result_q.pop_front();
            if (rsp_status !== want.st) begin
               $display("%0t ns: status expected %0d, got %0d", $time, want.st, rsp_status);
               err_cnt++;
            end
            if (rsp_read_byte !== want.data) begin
               $display("%0t ns: read_byte expected %0d, got %0d",
                        $time, want.data, rsp_read_byte);
               err_cnt++;
            end
            if (rsp_last !== want.last) begin
               $display("%0t ns: last expected %0d, got %0d", $time, want.last, rsp_last);
               err_cnt++;
            end
            if (rsp_fill_count !== want.fill) begin
               $display("%0t ns: fill_count expected %0d, got %0d",
                        $time, want.fill, rsp_fill_count);
               err_cnt++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic add_push(input logic [BYTE_W-1:0] b);
      beat_q.push_back('{KIND_PUSH, b, LEN_W'($urandom), 1'($urandom)});
   endtask

   task automatic add_read(input logic [LEN_W-1:0] len, input logic wm);
      beat_q.push_back('{KIND_READ, BYTE_W'($urandom), len, wm});
   endtask

   task automatic add_tick();
      beat_q.push_back('{KIND_TICK, BYTE_W'($urandom), LEN_W'($urandom), 1'($urandom)});
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (beat_q.size() != 0 || req_valid || result_q.size() != 0);
      repeat (10) @(posedge clock);
   endtask

   // Leave the block idle: no read waiting and nothing stored
   task automatic settle();
      int need;
      wait_drained();
      if (rd_waiting) begin
         need = int'(waiting_len) - int'(stored_bytes());
         repeat (need > 0 ? need : 0) add_push(BYTE_W'($urandom));
         add_tick();
         wait_drained();
      end
      while (stored_bytes() != 0) begin
         add_read(stored_bytes() > MAX_READ ? LEN_W'(MAX_READ) : LEN_W'(stored_bytes()), 1'b0);
         wait_drained();
      end
   endtask

   task automatic csr_write(input csr_reg_type which, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= which;
      csr_wdata <= val;
      do @(posedge clock);
      while (!csr_ready);
      if (which == CSR_TIMEOUT) timeout_cfg = val[TIMEOUT_W-1:0];
      else step_cfg = val[STEP_W-1:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_traffic(input int n_items);
      int done_cnt;
      int sel;
      int k;
      logic [LEN_W-1:0] len;
      done_cnt = 0;
      while (done_cnt < n_items) begin
         sel = $urandom_range(0, 99);
         if (sel < 35) begin
            k = $urandom_range(1, 6);
            repeat (k) add_push(BYTE_W'($urandom));
            done_cnt += k;
         end else if (sel < 55) begin
            // mostly short lengths, now and then anything the field holds
            len = ($urandom_range(0, 7) == 0) ? LEN_W'($urandom) : LEN_W'($urandom_range(0, 10));
            add_read(len, 1'($urandom));
            done_cnt++;
         end else if (sel < 75) begin
            // waiting read followed by the bytes and ticks that may satisfy it
            add_read(LEN_W'($urandom_range(1, 8)), 1'b1);
            k = $urandom_range(1, 8);
            repeat (k) begin
               if ($urandom_range(0, 1)) add_push(BYTE_W'($urandom));
               else add_tick();
            end
            done_cnt += k + 1;
         end else if (sel < 95) begin
            k = $urandom_range(1, 3);
            repeat (k) add_tick();
            done_cnt += k;
         end else begin
            beat_q.push_back('{KIND_UNUSED, BYTE_W'($urandom), LEN_W'($urandom), 1'($urandom)});
            done_cnt++;
         end
      end
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // reset values of the registers: empty, short, busy, retried waiting read
      add_read(7'd0, 1'b0);
      add_read(7'd1, 1'b0);
      add_push(8'h00);
      add_push(8'hFF);
      add_push(8'hA5);
      add_read(7'd3, 1'b0);
      beat_q.push_back('{KIND_UNUSED, BYTE_W'($urandom), LEN_W'($urandom), 1'($urandom)});
      add_tick();
      add_read(7'd2, 1'b1);
      add_read(7'd0, 1'b0);
      add_push(8'h5A);
      add_tick();
      add_push(8'h3C);
      add_tick();
      add_read(7'd127, 1'b0);
      settle();

      // zero timeout: short waiting read flushes at once
      csr_write(CSR_TIMEOUT, 16'd0);
      csr_write(CSR_POLL_STEP, 16'd1023);
      send_gap_pct = 71;
      add_push(BYTE_W'($urandom));
      add_push(BYTE_W'($urandom));
      add_read(7'd5, 1'b1);
      add_read(7'd0, 1'b0);
      random_traffic(14);
      settle();

      // longest budget, zero step counts as one
      csr_write(CSR_TIMEOUT, 16'hFFFF);
      csr_write(CSR_POLL_STEP, 16'd0);
      send_gap_pct = 0;
      rsp_hold_pct = 71;
      add_read(7'd3, 1'b1);
      add_tick();
      add_push(BYTE_W'($urandom));
      add_push(BYTE_W'($urandom));
      add_push(BYTE_W'($urandom));
      add_tick();
      random_traffic(14);
      settle();

      // one-tick budget: exhausting tick still retries, then times out
      csr_write(CSR_TIMEOUT, 16'd1);
      csr_write(CSR_POLL_STEP, 16'd1);
      send_gap_pct = 30;
      rsp_hold_pct = 30;
      add_read(7'd2, 1'b1);
      add_push(BYTE_W'($urandom));
      add_push(BYTE_W'($urandom));
      add_tick();
      add_read(7'd1, 1'b1);
      add_tick();
      random_traffic(14);
      settle();

      csr_write(CSR_TIMEOUT, 16'd95);
      csr_write(CSR_POLL_STEP, 16'd1000);
      send_gap_pct = 0;
      rsp_hold_pct = 0;
      random_traffic(14);
      settle();

      csr_write(CSR_TIMEOUT, CSR_DATA_W'($urandom_range(30, 600)));
      csr_write(CSR_POLL_STEP, CSR_DATA_W'($urandom_range(1, 100)));
      send_gap_pct = 30;
      rsp_hold_pct = 30;
      add_read(7'd5, 1'b0);
      random_traffic(14);
      wait_drained();

      if (err_cnt == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
